// ===== hw/rtl/rdde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdde_pkg;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_REVERSE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_EMIT    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ELEMENT = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    localparam int unsigned VALUE_W = 31;

    typedef struct packed {
        op_t                  op;
        logic [VALUE_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   element;
        logic                 last;
        logic                 overflowed;
    } res_t;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

endpackage : rdde_pkg

`default_nettype wire

// ===== hw/rtl/reversible_deque_drop_engine.sv =====
// Ring-buffer deque with a logical direction flag.
// Command channel (cmd_valid, cmd_stall, cmd): push, reverse, delete or emit.
// Result channel (res_valid, res_stall, res): items produced by an emit only.
// Push, reverse and delete take effect in the cycle they are accepted, and
// the block takes one such command per cycle while no drain is running.
// An emit with the error set, or with an empty store, puts one result in the
// output register on the next edge. Otherwise the block drains the store in
// logical order, one synchronous memory read per cycle through the single read
// port while the output path is not stalled; the command channel stays stalled
// until the last element is read, and each element passes through the read stage
// and then the output register.
// All deque state returns to empty when an emit is accepted, so commands that
// follow only write entries the drain has already read.
// An emit is held off while earlier results still occupy the output path.
// When the receiver stalls, the output register and a one-entry read stage
// hold their items and the drain pauses; nothing is lost or repeated.
// Reset clears pointers, count and flags; the memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module reversible_deque_drop_engine
    import rdde_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    logic [VALUE_W-1:0] ring_mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               rev_reg, rev_next;
    logic               err_reg, err_next;
    logic               ovf_reg, ovf_next;

    logic [AW-1:0]      drain_ptr_reg, drain_ptr_next;
    logic [CW-1:0]      drain_left_reg, drain_left_next;
    logic               drain_rev_reg, drain_rev_next;
    logic               drain_ovf_reg, drain_ovf_next;

    logic               st_valid_reg, st_valid_next;
    logic               st_last_reg, st_last_next;
    logic               st_ovf_reg, st_ovf_next;

    logic               out_valid_reg, out_valid_next;
    res_t               out_data_reg, out_data_next;

    logic               out_take;
    logic               cmd_fire;
    logic               rd_en;
    logic               wr_en;
    logic               emit_direct;
    logic               emit_drain;

    assign out_take = !out_valid_reg || !res_stall;
    assign cmd_fire = cmd_valid && !cmd_stall;
    assign emit_direct = cmd_fire && (cmd.op == OP_EMIT) && (err_reg || fill_reg == '0);
    assign emit_drain  = cmd_fire && (cmd.op == OP_EMIT) && !err_reg && fill_reg != '0;
    assign wr_en = cmd_fire && (cmd.op == OP_PUSH) && (fill_reg != CW'(DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (emit_drain)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (rd_en && drain_left_reg == CW'(1))
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Handshake and memory read control.
    always_comb
    begin
        cmd_stall = 1'b0;
        rd_en     = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                // An emit needs the whole output path empty or emptying.
                cmd_stall = (cmd.op == OP_EMIT) && (st_valid_reg || !out_take);
            end
            ST_DRAIN:
            begin
                cmd_stall = 1'b1;
                rd_en     = !st_valid_reg || out_take;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Deque bookkeeping and result path.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        rev_next        = rev_reg;
        err_next        = err_reg;
        ovf_next        = ovf_reg;
        drain_ptr_next  = drain_ptr_reg;
        drain_left_next = drain_left_reg;
        drain_rev_next  = drain_rev_reg;
        drain_ovf_next  = drain_ovf_reg;
        st_valid_next   = st_valid_reg;
        st_last_next    = st_last_reg;
        st_ovf_next     = st_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (cmd_fire)
        begin
            case (cmd.op)
                OP_PUSH:
                begin
                    if (fill_reg == CW'(DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        tail_next = ptr_inc(tail_reg);
                        fill_next = fill_reg + CW'(1);
                    end
                end
                OP_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                OP_DELETE:
                begin
                    if (!err_reg)
                    begin
                        if (fill_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (rev_reg)
                            begin
                                tail_next = ptr_dec(tail_reg);
                            end
                            else
                            begin
                                head_next = ptr_inc(head_reg);
                            end
                            fill_next = fill_reg - CW'(1);
                        end
                    end
                end
                OP_EMIT:
                begin
                    drain_ptr_next  = rev_reg ? ptr_dec(tail_reg) : head_reg;
                    drain_left_next = fill_reg;
                    drain_rev_next  = rev_reg;
                    drain_ovf_next  = ovf_reg;
                    head_next       = '0;
                    tail_next       = '0;
                    fill_next       = '0;
                    rev_next        = 1'b0;
                    err_next        = 1'b0;
                    ovf_next        = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (rd_en)
        begin
            drain_ptr_next  = drain_rev_reg ? ptr_dec(drain_ptr_reg) : ptr_inc(drain_ptr_reg);
            drain_left_next = drain_left_reg - CW'(1);
        end

        // Output register: drained element first, else a direct emit result.
        if (st_valid_reg && out_take)
        begin
            out_valid_next             = 1'b1;
            out_data_next.kind         = KIND_ELEMENT;
            out_data_next.element      = rdata_reg;
            out_data_next.last         = st_last_reg;
            out_data_next.overflowed   = st_ovf_reg;
        end
        else if (emit_direct)
        begin
            out_valid_next             = 1'b1;
            out_data_next.kind         = err_reg ? KIND_ERROR : KIND_EMPTY;
            out_data_next.element      = '0;
            out_data_next.last         = 1'b1;
            out_data_next.overflowed   = ovf_reg;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_en)
        begin
            st_valid_next = 1'b1;
            st_last_next  = (drain_left_reg == CW'(1));
            st_ovf_next   = drain_ovf_reg;
        end
        else if (out_take)
        begin
            st_valid_next = 1'b0;
        end
    end

    // Writes happen only in the run state and reads only while draining, and the
    // drain reads entries that the emit has already released, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[tail_reg] <= cmd.value;
        end
        if (rd_en)
        begin
            rdata_reg <= ring_mem[drain_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            rev_reg        <= 1'b0;
            err_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            drain_left_reg <= '0;
            st_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            rev_reg        <= rev_next;
            err_reg        <= err_next;
            ovf_reg        <= ovf_next;
            drain_left_reg <= drain_left_next;
            st_valid_reg   <= st_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_ptr_reg <= drain_ptr_next;
        drain_rev_reg <= drain_rev_next;
        drain_ovf_reg <= drain_ovf_next;
        st_last_reg   <= st_last_next;
        st_ovf_reg    <= st_ovf_next;
        out_data_reg  <= out_data_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

    // The deque is already empty for new commands while a drain runs.
    a_drain_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (fill_reg == '0 && !err_reg))
        else $error("deque state not cleared during drain");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> st_valid_reg)
        else $error("memory read did not land in the read stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && out_valid_reg && res_stall) |=> (st_valid_reg && $stable(rdata_reg)))
        else $error("read stage lost its item under stall");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind != KIND_ELEMENT) |-> out_data_reg.last)
        else $error("empty or error result not marked last");

    a_no_emit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.op == OP_EMIT) |-> !st_valid_reg)
        else $error("emit accepted while drained items remain in flight");

endmodule : reversible_deque_drop_engine

`default_nettype wire

// ===== tb/tb_reversible_deque_drop_engine.sv =====
`timescale 1ns / 1ps

module tb_reversible_deque_drop_engine
    import rdde_pkg::*;
();

    localparam int DEPTH = 64;
    localparam int RANDOM_ITEMS = 200;
    localparam longint CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    reversible_deque_drop_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the deque, updated as each command item is accepted.
    logic [VALUE_W-1:0] shadow_mem [DEPTH];
    logic [5:0]         head_idx = '0;
    logic [5:0]         tail_idx = '0;
    logic [6:0]         fill = '0;
    logic               rev_dir = 1'b0;
    logic               err_seen = 1'b0;
    logic               ovf_seen = 1'b0;

    res_t   expected_drain [$];
    int     fail_count = 0;
    int     src_pace = 1;
    int     sink_pace = 1;
    int     stall_len = 0;
    longint cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Pace 0 never idles, pace 1 idles now and then, pace 2 idles often.
    function automatic int pick_delay(input int pace);
        int r;
        r = $urandom_range(0, 99);
        if (pace == 0)
            return 0;
        if (pace == 1)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 30)
            return 0;
        if (r < 80)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_len > 0)
        begin
            res_stall <= 1'b1;
            stall_len <= stall_len - 1;
        end
        else if (pick_delay(sink_pace) > 0)
        begin
            res_stall <= 1'b1;
            stall_len <= pick_delay(sink_pace);
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    task automatic push_expect(input kind_t k, input logic [VALUE_W-1:0] e, input logic lst);
        res_t r;
        r.kind = k;
        r.element = e;
        r.last = lst;
        r.overflowed = ovf_seen;
        expected_drain.push_back(r);
    endtask

    task automatic deque_predict(input cmd_t c);
        logic [5:0] p;
        int i;
        case (c.op)
            OP_PUSH:
            begin
                if (fill == DEPTH)
                    ovf_seen = 1'b1;
                else
                begin
                    shadow_mem[tail_idx] = c.value;
                    tail_idx = tail_idx + 6'd1;
                    fill = fill + 7'd1;
                end
            end
            OP_REVERSE:
                rev_dir = ~rev_dir;
            OP_DELETE:
            begin
                if (!err_seen)
                begin
                    if (fill == 0)
                        err_seen = 1'b1;
                    else
                    begin
                        if (rev_dir)
                            tail_idx = tail_idx - 6'd1;
                        else
                            head_idx = head_idx + 6'd1;
                        fill = fill - 7'd1;
                    end
                end
            end
            default:
            begin
                if (err_seen)
                    push_expect(KIND_ERROR, '0, 1'b1);
                else if (fill == 0)
                    push_expect(KIND_EMPTY, '0, 1'b1);
                else
                begin
                    p = rev_dir ? tail_idx - 6'd1 : head_idx;
                    for (i = 0; i < fill; i++)
                    begin
                        push_expect(KIND_ELEMENT, shadow_mem[p], i == fill - 1);
                        p = rev_dir ? p - 6'd1 : p + 6'd1;
                    end
                end
                head_idx = '0;
                tail_idx = '0;
                fill = '0;
                rev_dir = 1'b0;
                err_seen = 1'b0;
                ovf_seen = 1'b0;
            end
        endcase
    endtask

    // Handshake signals only move at rising edges, so the falling edge sees
    // the values that the next rising edge will act on.
    always @(negedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_drain.size() == 0)
            begin
                $error("result item with nothing expected: kind %0d element %0h",
                       res.kind, res.element);
                fail_count++;
            end
            else
            begin
                res_t want;
                want = expected_drain.pop_front();
                if (res.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, res.kind);
                    fail_count++;
                end
                if (res.element !== want.element)
                begin
                    $error("element: expected %0h, actual %0h", want.element, res.element);
                    fail_count++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, res.last);
                    fail_count++;
                end
                if (res.overflowed !== want.overflowed)
                begin
                    $error("overflowed: expected %0b, actual %0b",
                           want.overflowed, res.overflowed);
                    fail_count++;
                end
            end
        end
    end

    // Called right after a rising edge; returns right after the edge that
    // accepted the item, with cmd_valid still high.
    task automatic send_cmd(input op_t op, input logic [VALUE_W-1:0] v = '0);
        int gap;
        cmd_t c;
        c.op = op;
        c.value = v;
        gap = pick_delay(src_pace);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(negedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        deque_predict(c);
        @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        return VALUE_W'($urandom());
    endfunction

    task automatic test_empty_emit();
        send_cmd(OP_EMIT);
        send_cmd(OP_REVERSE);
        send_cmd(OP_EMIT);
    endtask

    task automatic test_value_extremes();
        send_cmd(OP_PUSH, '0);
        send_cmd(OP_PUSH, '1);
        send_cmd(OP_PUSH, 31'h5555_5555);
        send_cmd(OP_PUSH, 31'h2AAA_AAAA);
        send_cmd(OP_EMIT);
    endtask

    task automatic test_reverse_delete();
        int i;
        for (i = 0; i < 5; i++)
            send_cmd(OP_PUSH, rand_value());
        send_cmd(OP_DELETE);
        send_cmd(OP_REVERSE);
        send_cmd(OP_DELETE);
        send_cmd(OP_PUSH, rand_value());
        send_cmd(OP_EMIT);
    endtask

    // A delete on an empty store latches the error; later pushes still land,
    // later deletes are ignored, and the first emit reports only the error.
    task automatic test_error_path();
        send_cmd(OP_DELETE);
        send_cmd(OP_PUSH, rand_value());
        send_cmd(OP_DELETE);
        send_cmd(OP_REVERSE);
        send_cmd(OP_EMIT);
        send_cmd(OP_EMIT);
    endtask

    // Fills past capacity, then walks the tail pointer across the wrap point both ways.
    task automatic test_full_and_wrap();
        int i;
        sink_pace = 2;
        for (i = 0; i < DEPTH + 2; i++)
            send_cmd(OP_PUSH, rand_value());
        send_cmd(OP_EMIT);
        sink_pace = 0;
        src_pace = 0;
        for (i = 0; i < DEPTH; i++)
            send_cmd(OP_PUSH, rand_value());
        for (i = 0; i < 3; i++)
            send_cmd(OP_DELETE);
        for (i = 0; i < 4; i++)
            send_cmd(OP_PUSH, rand_value());
        send_cmd(OP_REVERSE);
        for (i = 0; i < 4; i++)
            send_cmd(OP_DELETE);
        send_cmd(OP_EMIT);
        for (i = 0; i < DEPTH; i++)
            send_cmd(OP_PUSH, rand_value());
        send_cmd(OP_REVERSE);
        send_cmd(OP_DELETE);
        send_cmd(OP_REVERSE);
        send_cmd(OP_DELETE);
        send_cmd(OP_EMIT);
        src_pace = 1;
        sink_pace = 1;
    endtask

    // Mostly well-formed bursts of push, reverse and delete closed by an emit;
    // the rest is unconstrained noise that can hit delete on empty.
    task automatic test_random();
        int sent;
        int len;
        int i;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            src_pace = $urandom_range(0, 2);
            sink_pace = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 72)
                                                  : $urandom_range(1, 10);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        send_cmd(OP_REVERSE, rand_value());
                    else if (r < 40 && fill != 0)
                        send_cmd(OP_DELETE, rand_value());
                    else
                        send_cmd(OP_PUSH, rand_value());
                end
                send_cmd(OP_EMIT, rand_value());
                sent += len + 1;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    send_cmd(op_t'($urandom_range(0, 3)), rand_value());
                sent += len;
            end
        end
        send_cmd(OP_EMIT, rand_value());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_emit();
        test_value_extremes();
        test_reverse_delete();
        test_error_path();
        test_full_and_wrap();
        test_random();
        cmd_valid <= 1'b0;
        while (expected_drain.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rdde_pkg.sv
hw/rtl/reversible_deque_drop_engine.sv
tb/tb_reversible_deque_drop_engine.sv
